[hdl/assert_macros.svh]
// Assertion macros for the RTL files that carry checks.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

[hdl/i2cbm_pkg.sv]
// Package for the bit-level I2C master: payload structs, config struct,
// command, phase and register index codes. No dependencies.
`default_nettype none

package i2cbm_pkg;

    localparam int BITS_PER_TRANSFER = 8;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_sampled;
    } in_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive_enable;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_failed;
    } out_t;

    typedef struct packed {
        logic [15:0] half_period_ticks;
        logic [7:0]  ack_timeout_limit;
    } cfg_t;

    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_STOP  = 3'd2;
    localparam logic [2:0] CMD_WRITE = 3'd3;
    localparam logic [2:0] CMD_READ  = 3'd4;
    localparam logic [2:0] CMD_WAIT  = 3'd5;

    localparam logic [1:0] REG_HALF_PERIOD = 2'd0;
    localparam logic [1:0] REG_ACK_TIMEOUT = 2'd1;

    localparam logic [15:0] HALF_PERIOD_RESET = 16'd100;
    localparam logic [7:0]  ACK_TIMEOUT_RESET = 8'd250;

    localparam logic [3:0] PH_IDLE = 4'd0;
    localparam logic [3:0] PH_ST1  = 4'd1;
    localparam logic [3:0] PH_ST2  = 4'd2;
    localparam logic [3:0] PH_SP1  = 4'd3;
    localparam logic [3:0] PH_SP2  = 4'd4;
    localparam logic [3:0] PH_WA1  = 4'd5;
    localparam logic [3:0] PH_WA2  = 4'd6;
    localparam logic [3:0] PH_WAP  = 4'd7;
    localparam logic [3:0] PH_WRR  = 4'd8;
    localparam logic [3:0] PH_WRH  = 4'd9;
    localparam logic [3:0] PH_WRL  = 4'd10;
    localparam logic [3:0] PH_RDL  = 4'd11;
    localparam logic [3:0] PH_RDH  = 4'd12;
    localparam logic [3:0] PH_AKL  = 4'd13;
    localparam logic [3:0] PH_AKH  = 4'd14;

endpackage

`default_nettype wire

[hdl/i2cbm_seq.sv]
// Pin-level sequencer for the I2C master: phase register, counters, shifter,
// line levels. Advances one tick per step. Depends on i2cbm_pkg.
`default_nettype none

module i2cbm_seq (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            step,
    input  wire i2cbm_pkg::in_t  in_data,
    input  wire i2cbm_pkg::cfg_t cfg,
    output i2cbm_pkg::out_t      result
);

    logic [3:0]  phase_reg, phase_next;
    logic [2:0]  cmd_reg, cmd_next;
    logic [3:0]  bits_reg, bits_next;
    logic [7:0]  shift_reg, shift_next;
    logic [15:0] delay_reg, delay_next;
    logic [7:0]  tmo_reg, tmo_next;
    logic        scl_reg, scl_next;
    logic        sda_reg, sda_next;
    logic        drv_reg, drv_next;
    logic        ack_reg, ack_next;
    logic [7:0]  rx_reg, rx_next;
    logic        done, failed;

    logic [15:0] delay_load;
    logic        dly_run;
    logic [15:0] dly_dec;
    logic [3:0]  bits_inc;

    assign delay_load = (cfg.half_period_ticks == 16'd0) ? 16'd1 : cfg.half_period_ticks;
    assign dly_run    = delay_reg > 16'd1;
    assign dly_dec    = delay_reg - 16'd1;
    assign bits_inc   = bits_reg + 4'd1;

    always_comb
    begin
        phase_next = phase_reg;
        cmd_next   = cmd_reg;
        bits_next  = bits_reg;
        shift_next = shift_reg;
        delay_next = delay_reg;
        tmo_next   = tmo_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        drv_next   = drv_reg;
        ack_next   = ack_reg;
        rx_next    = rx_reg;
        done       = 1'b0;
        failed     = 1'b0;

        case (phase_reg)
            i2cbm_pkg::PH_IDLE:
            begin
                case (in_data.command)
                    i2cbm_pkg::CMD_START:
                    begin
                        cmd_next   = in_data.command;
                        {scl_next, sda_next, drv_next} = 3'b111;
                        phase_next = i2cbm_pkg::PH_ST1;
                        delay_next = delay_load;
                    end
                    i2cbm_pkg::CMD_STOP:
                    begin
                        cmd_next   = in_data.command;
                        {scl_next, sda_next, drv_next} = 3'b001;
                        phase_next = i2cbm_pkg::PH_SP1;
                        delay_next = delay_load;
                    end
                    i2cbm_pkg::CMD_WRITE:
                    begin
                        cmd_next   = in_data.command;
                        bits_next  = 4'd0;
                        {scl_next, sda_next, drv_next} = {1'b0, in_data.tx_byte[7], 1'b1};
                        shift_next = {in_data.tx_byte[6:0], 1'b0};
                        phase_next = i2cbm_pkg::PH_WRR;
                    end
                    i2cbm_pkg::CMD_READ:
                    begin
                        cmd_next   = in_data.command;
                        shift_next = 8'd0;
                        bits_next  = 4'd0;
                        ack_next   = in_data.send_ack;
                        scl_next   = 1'b0;
                        drv_next   = 1'b0;
                        phase_next = i2cbm_pkg::PH_RDL;
                        delay_next = delay_load;
                    end
                    i2cbm_pkg::CMD_WAIT:
                    begin
                        cmd_next   = in_data.command;
                        sda_next   = 1'b1;
                        drv_next   = 1'b0;
                        phase_next = i2cbm_pkg::PH_WA1;
                        delay_next = delay_load;
                    end
                    default:
                    begin
                        phase_next = i2cbm_pkg::PH_IDLE;
                    end
                endcase
            end
            i2cbm_pkg::PH_ST1:
            begin
                if (dly_run)
                    delay_next = dly_dec;
                else
                begin
                    {scl_next, sda_next, drv_next} = 3'b101;
                    phase_next = i2cbm_pkg::PH_ST2;
                    delay_next = delay_load;
                end
            end
            i2cbm_pkg::PH_ST2:
            begin
                if (dly_run)
                    delay_next = dly_dec;
                else
                begin
                    scl_next = 1'b0;
                    done     = 1'b1;
                end
            end
            i2cbm_pkg::PH_SP1:
            begin
                if (dly_run)
                    delay_next = dly_dec;
                else
                begin
                    {scl_next, sda_next, drv_next} = 3'b111;
                    phase_next = i2cbm_pkg::PH_SP2;
                    delay_next = delay_load;
                end
            end
            i2cbm_pkg::PH_SP2:
            begin
                if (dly_run)
                    delay_next = dly_dec;
                else
                begin
                    done   = 1'b1;
                    // stop issued after an ack timeout
                    failed = (cmd_reg == i2cbm_pkg::CMD_WAIT);
                end
            end
            i2cbm_pkg::PH_WA1:
            begin
                if (dly_run)
                    delay_next = dly_dec;
                else
                begin
                    scl_next   = 1'b1;
                    phase_next = i2cbm_pkg::PH_WA2;
                    delay_next = delay_load;
                end
            end
            i2cbm_pkg::PH_WA2:
            begin
                if (dly_run)
                    delay_next = dly_dec;
                else
                begin
                    tmo_next   = 8'd0;
                    phase_next = i2cbm_pkg::PH_WAP;
                end
            end
            i2cbm_pkg::PH_WAP:
            begin
                if (!in_data.sda_sampled)
                begin
                    scl_next = 1'b0;
                    done     = 1'b1;
                end
                else if (tmo_reg >= cfg.ack_timeout_limit)
                begin
                    {scl_next, sda_next, drv_next} = 3'b001;
                    phase_next = i2cbm_pkg::PH_SP1;
                    delay_next = delay_load;
                end
                else
                    tmo_next = tmo_reg + 8'd1;
            end
            i2cbm_pkg::PH_WRR:
            begin
                scl_next   = 1'b1;
                phase_next = i2cbm_pkg::PH_WRH;
                delay_next = delay_load;
            end
            i2cbm_pkg::PH_WRH:
            begin
                if (dly_run)
                    delay_next = dly_dec;
                else
                begin
                    scl_next   = 1'b0;
                    phase_next = i2cbm_pkg::PH_WRL;
                    delay_next = delay_load;
                end
            end
            i2cbm_pkg::PH_WRL:
            begin
                if (dly_run)
                    delay_next = dly_dec;
                else
                begin
                    bits_next = bits_inc;
                    if (bits_inc >= 4'(i2cbm_pkg::BITS_PER_TRANSFER))
                        done = 1'b1;
                    else
                    begin
                        {scl_next, sda_next, drv_next} = {1'b0, shift_reg[7], 1'b1};
                        shift_next = {shift_reg[6:0], 1'b0};
                        phase_next = i2cbm_pkg::PH_WRR;
                    end
                end
            end
            i2cbm_pkg::PH_RDL:
            begin
                if (dly_run)
                    delay_next = dly_dec;
                else
                begin
                    scl_next   = 1'b1;
                    phase_next = i2cbm_pkg::PH_RDH;
                    delay_next = delay_load;
                end
            end
            i2cbm_pkg::PH_RDH:
            begin
                if (dly_run)
                    delay_next = dly_dec;
                else
                begin
                    shift_next = {shift_reg[6:0], in_data.sda_sampled};
                    bits_next  = bits_inc;
                    delay_next = delay_load;
                    if (bits_inc >= 4'(i2cbm_pkg::BITS_PER_TRANSFER))
                    begin
                        {scl_next, sda_next, drv_next} = {1'b0, ~ack_reg, 1'b1};
                        phase_next = i2cbm_pkg::PH_AKL;
                    end
                    else
                    begin
                        scl_next   = 1'b0;
                        phase_next = i2cbm_pkg::PH_RDL;
                    end
                end
            end
            i2cbm_pkg::PH_AKL:
            begin
                if (dly_run)
                    delay_next = dly_dec;
                else
                begin
                    scl_next   = 1'b1;
                    phase_next = i2cbm_pkg::PH_AKH;
                    delay_next = delay_load;
                end
            end
            i2cbm_pkg::PH_AKH:
            begin
                if (dly_run)
                    delay_next = dly_dec;
                else
                begin
                    scl_next = 1'b0;
                    rx_next  = shift_reg;
                    done     = 1'b1;
                end
            end
            default:
            begin
                phase_next = i2cbm_pkg::PH_IDLE;
            end
        endcase

        if (done)
            phase_next = i2cbm_pkg::PH_IDLE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= i2cbm_pkg::PH_IDLE;
            cmd_reg   <= 3'd0;
            bits_reg  <= 4'd0;
            shift_reg <= 8'd0;
            delay_reg <= 16'd0;
            tmo_reg   <= 8'd0;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
            drv_reg   <= 1'b1;
            ack_reg   <= 1'b0;
            rx_reg    <= 8'd0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            cmd_reg   <= cmd_next;
            bits_reg  <= bits_next;
            shift_reg <= shift_next;
            delay_reg <= delay_next;
            tmo_reg   <= tmo_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            drv_reg   <= drv_next;
            ack_reg   <= ack_next;
            rx_reg    <= rx_next;
        end
    end

    always_comb
    begin
        result.scl_level        = scl_next;
        result.sda_level        = sda_next;
        result.sda_drive_enable = drv_next;
        result.busy_res         = (phase_next != i2cbm_pkg::PH_IDLE);
        result.done_res         = done;
        result.rx_byte          = rx_next;
        result.ack_failed       = failed;
    end

endmodule

`default_nettype wire

[hdl/i2c_bit_level_master_top.sv]
// Top level of the bit-level I2C master: handshake, config registers,
// result register. Depends on i2cbm_pkg, i2cbm_seq and assert_macros.svh.
//
//   channel   direction   signals                           transaction
//   in        input       in_valid/in_ready/in_data         one bus tick
//   out       output      out_valid/out_ready/out_data      one result per tick
//   cfg       input       cfg_we/cfg_index/cfg_data         one register write
//
// One tick per cycle unless the output stalls: the sequencer updates in the cycle
// a tick is accepted and its result is registered for the next cycle.
// Reset puts SCL and SDA high and driven, idle, half period 100, timeout 250.
// A stalled result holds in_ready low only while out_ready is low; a new tick
// is accepted in the same cycle the held result is taken.
`default_nettype none
`include "assert_macros.svh"

module i2c_bit_level_master_top (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire i2cbm_pkg::in_t  in_data,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output i2cbm_pkg::out_t      out_data,
    input  wire logic            cfg_we,
    input  wire logic [1:0]      cfg_index,
    input  wire logic [15:0]     cfg_data
);

    i2cbm_pkg::cfg_t cfg_reg;
    i2cbm_pkg::out_t result;
    i2cbm_pkg::out_t out_data_reg;
    logic            out_valid_reg;
    logic            step;

    assign in_ready  = !out_valid_reg || out_ready;
    assign step      = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.half_period_ticks <= i2cbm_pkg::HALF_PERIOD_RESET;
            cfg_reg.ack_timeout_limit <= i2cbm_pkg::ACK_TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                i2cbm_pkg::REG_HALF_PERIOD: cfg_reg.half_period_ticks <= cfg_data;
                i2cbm_pkg::REG_ACK_TIMEOUT: cfg_reg.ack_timeout_limit <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    i2cbm_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .in_data (in_data),
        .cfg     (cfg_reg),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            out_data_reg <= result;
    end

    `ASSERT_ALWAYS(a_fail_with_done, clk, rst_n,
        !(out_valid && out_data.ack_failed) || out_data.done_res,
        "ack_failed without done")
    `ASSERT_ALWAYS(a_done_not_busy, clk, rst_n,
        !(out_valid && out_data.done_res) || !out_data.busy_res,
        "done while still busy")
    `ASSERT_NEXT(a_tick_gives_result, clk, rst_n, step, out_valid,
        "accepted tick left no result")

endmodule

`default_nettype wire
